/* design/lkvc_pkg.sv */
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants of the lru key-value cache
// widths of the request and result fields, command codes and the records
// that move along the row of entry cells
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int KEY_W           = 32;
    localparam int VAL_W           = 32;
    localparam int CAP_W           = 5;

    localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
    localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_SET = 1'b1;

    // lookup wave that walks down the row, one cell per cycle
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic             found;
        logic [VAL_W-1:0] value;
    } wave_t;

    // contents of one cell
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

    // update command broadcast to all cells
    typedef struct packed {
        logic commit;
        logic by_flag;
        logic room;
    } cmd_t;

endpackage

/* design/lru_key_value_cache.sv */
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value store, lru replacement
// get and set requests against a row of entry cells kept in recency order
// ----------------------------------------------------------------------------
// Entries sit in a row of MAX_ENTRIES cells ordered by recency, cell 0 being
// the most recent, so an entry's rank is simply its position. For each request
// one lookup wave walks the row one cell per cycle, then a move step brings the
// touched or inserted entry to the front while the cells above it shift down by
// one, and the block then returns to idle and takes the next request. A get whose
// result register is still held by an unaccepted result waits in the move step
// until the m_ channel takes the older result.
// Only one request is in flight; the next is accepted while a get result is
// still waiting on the m_ channel. A set gives no result; a get gives one with
// hit and the stored value, or hit low and all ones on a miss. Capacity is
// clamped to 1 .. MAX_ENTRIES; lowering it below the fill level evicts
// nothing until the next insert, which then replaces the least recent entry.
// Write the capacity only while the block is idle.
module lru_key_value_cache #(
    parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_mode,
    input  logic signed [lkvc_pkg::KEY_W-1:0] s_key_in,
    input  logic signed [lkvc_pkg::VAL_W-1:0] s_value_in,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_hit,
    output logic signed [lkvc_pkg::VAL_W-1:0] m_value_out,
    // capacity register write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic        [lkvc_pkg::CAP_W-1:0] cfg_data
);
    import lkvc_pkg::*;

    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
    localparam int CNT_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_DONE   = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic             mode_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;
    logic             found_reg;
    logic [VAL_W-1:0] fval_reg;
    logic [OCC_W-1:0] occ_reg;
    logic [CAP_W-1:0] cap_reg;
    logic             m_valid_reg;
    logic             m_hit_reg;
    logic [VAL_W-1:0] m_value_reg;

    wave_t  wave_chain [0:MAX_ENTRIES];
    entry_t entry_q    [0:MAX_ENTRIES-1];
    entry_t head_entry;
    cmd_t   cmd;

    logic                   s_fire;
    logic                   commit;
    logic                   room;
    logic [CNT_W-1:0]       cap_ext;
    logic [CNT_W-1:0]       cap_eff;
    logic [MAX_ENTRIES-1:0] valid_vec;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // effective capacity: zero acts as one, anything above the row is the row
    assign cap_ext = CNT_W'(cap_reg);
    always_comb begin
        if (cap_ext == '0) begin
            cap_eff = CNT_W'(1);
        end else if (cap_ext > MAX_CNT) begin
            cap_eff = MAX_CNT;
        end else begin
            cap_eff = cap_ext;
        end
    end
    assign room = (CNT_W'(occ_reg) < cap_eff);

    // the lookup wave is launched at the head of the row with the request key
    always_comb begin
        wave_chain[0]       = '0;
        wave_chain[0].valid = s_fire;
        wave_chain[0].key   = s_key_in;
        wave_chain[0].value = MISS_VALUE;
    end

    // a result can only be loaded when the output register is free or draining
    assign commit = (state_reg == ST_DONE) &&
                    ((mode_reg == MODE_SET) || !m_valid_reg || m_ready);

    // a get miss leaves the row alone
    assign cmd.commit  = commit && ((mode_reg == MODE_SET) || found_reg);
    assign cmd.by_flag = found_reg;
    assign cmd.room    = room;

    // the touched or new entry enters at the front
    assign head_entry.valid = 1'b1;
    assign head_entry.key   = key_reg;
    assign head_entry.value = (mode_reg == MODE_SET) ? value_reg : fval_reg;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
            lkvc_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .wave_in    (wave_chain[gi]),
                .wave_out   (wave_chain[gi+1]),
                .prev_entry ((gi == 0) ? head_entry : entry_q[(gi == 0) ? 0 : gi-1]),
                .entry      (entry_q[gi]),
                .cmd        (cmd)
            );
            assign valid_vec[gi] = entry_q[gi].valid;
        end
    endgenerate

    // request sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (wave_chain[MAX_ENTRIES].valid) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            occ_reg     <= '0;
            cap_reg     <= CAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
            // hold the request for the update at the end of the wave
            if (s_fire) begin
                mode_reg  <= s_mode;
                key_reg   <= s_key_in;
                value_reg <= s_value_in;
            end
            // wave leaves the last cell with the lookup outcome
            if (state_reg == ST_SEARCH && wave_chain[MAX_ENTRIES].valid) begin
                found_reg <= wave_chain[MAX_ENTRIES].found;
                fval_reg  <= wave_chain[MAX_ENTRIES].value;
            end
            // fill level grows only on an insert into a free cell
            if (commit && mode_reg == MODE_SET && !found_reg && room) begin
                occ_reg <= occ_reg + OCC_W'(1);
            end
            // output register: a get transaction loads it
            if (commit && mode_reg == MODE_GET) begin
                m_valid_reg <= 1'b1;
                m_hit_reg   <= found_reg;
                m_value_reg <= found_reg ? fval_reg : MISS_VALUE;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_hit       = m_hit_reg;
    assign m_value_out = m_value_reg;

    // no wave may reach the end of the row unless a request is being searched
    a_wave_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        wave_chain[MAX_ENTRIES].valid |-> (state_reg == ST_SEARCH))
        else $error("lookup wave left the row outside a search");

    // fill count agrees with the cells that hold an entry
    a_occ_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == int'(occ_reg))
        else $error("fill count out of step with cell valid bits");

    // filled cells form one run from the front of the row
    a_valid_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        ((MAX_ENTRIES'(valid_vec + 1'b1)) & valid_vec) == '0)
        else $error("gap among filled cells");

    // a result appears only after a get is finished
    a_result_from_get: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE && mode_reg == MODE_GET))
        else $error("result raised without a finished get");

endmodule

/* design/lkvc_cell.sv */
// ----------------------------------------------------------------------------
// lkvc_cell: one entry of the recency-ordered row
// holds one key-value pair, compares it against the passing lookup wave and
// takes its upper neighbor's entry when the row shifts
// ----------------------------------------------------------------------------
module lkvc_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  lkvc_pkg::wave_t  wave_in,
    output lkvc_pkg::wave_t  wave_out,
    input  lkvc_pkg::entry_t prev_entry,
    output lkvc_pkg::entry_t entry,
    input  lkvc_pkg::cmd_t   cmd
);
    import lkvc_pkg::*;

    logic             valid_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;
    logic             flag_reg;
    wave_t            wave_reg;
    wave_t            wave_next;
    logic             match;
    logic             shift;

    assign match = wave_in.valid && !wave_in.found && valid_reg && (key_reg == wave_in.key);

    always_comb begin
        wave_next       = wave_in;
        wave_next.found = wave_in.found | match;
        wave_next.value = match ? value_reg : wave_in.value;
    end

    // on a hit only cells at or above the hit shift; on an insert the filled
    // cells shift, plus the first empty one when there is room
    assign shift = cmd.commit &&
                   (cmd.by_flag ? flag_reg : (valid_reg || (prev_entry.valid && cmd.room)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            wave_reg  <= '0;
        end else begin
            wave_reg <= wave_next;
            if (wave_in.valid) begin
                flag_reg <= !wave_in.found;
            end
            if (shift) begin
                valid_reg <= prev_entry.valid;
                key_reg   <= prev_entry.key;
                value_reg <= prev_entry.value;
            end
        end
    end

    assign wave_out    = wave_reg;
    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.value = value_reg;

endmodule
